FILE: rtl/core/sbsp_pkg.sv
// Shared types, constants and helper functions for the six-bit stream packer.
// Depends on nothing; every other file of the block imports this package.
`default_nettype none

package sbsp_pkg;

	localparam int unsigned WORD_W        = 48;
	localparam int unsigned BYTE_W        = 8;
	localparam int unsigned POS_W         = 3;
	localparam int unsigned BIDX_W        = 3;
	localparam int unsigned QUEUE_DEPTH_D = 4;

	// One packed group on its way from the front end to the serializer.
	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [BIDX_W-1:0] nbytes_m1;
		logic              last;
	} pack_entry_t;

	// Number of output bytes, minus one, for a group whose final item sat at
	// position pos; this is ceil(6*(pos+1)/8) - 1.
	function automatic logic [BIDX_W-1:0] nbytes_m1_of(input logic [POS_W-1:0] pos);
		logic [BIDX_W-1:0] r;
		begin
			case (pos)
				3'd0:    r = 3'd0;
				3'd1:    r = 3'd1;
				3'd2:    r = 3'd2;
				3'd3:    r = 3'd2;
				3'd4:    r = 3'd3;
				3'd5:    r = 3'd4;
				3'd6:    r = 3'd5;
				default: r = 3'd5;
			endcase
			return r;
		end
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sbsp_front.sv
// Front end of the packer: accepts bytes and assembles 48-bit groups.
// Depends on sbsp_pkg; feeds sbsp_queue.
`default_nettype none

module sbsp_front (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire  [sbsp_pkg::BYTE_W-1:0]   in_byte,
	input  wire                           in_last,
	input  wire                           push,
	input  wire                           q_full,
	output logic                          q_push,
	output sbsp_pkg::pack_entry_t         q_entry
);
	import sbsp_pkg::*;

	logic [WORD_W-1:0]        word_q;
	logic [POS_W-1:0]         pos_q;
	logic [5:0]               shamt;
	logic [WORD_W+BYTE_W-1:0] ext;
	logic [WORD_W-1:0]        next_word;
	logic                     accept;
	logic                     close_group;

	// Position k lands at bit 6k; 6k is formed as 4k + 2k.
	assign shamt       = {1'b0, pos_q, 2'b00} + {2'b00, pos_q, 1'b0};
	assign ext         = {{WORD_W{1'b0}}, in_byte} << shamt;
	assign next_word   = word_q | ext[WORD_W-1:0];
	assign accept      = push && !q_full;
	assign close_group = (pos_q == POS_W'(7)) || in_last;

	assign q_push            = accept && close_group;
	assign q_entry.word      = next_word;
	assign q_entry.nbytes_m1 = nbytes_m1_of(pos_q);
	assign q_entry.last      = in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
			pos_q  <= '0;
		end else if (accept) begin
			if (close_group) begin
				word_q <= '0;
				pos_q  <= '0;
			end else begin
				word_q <= next_word;
				pos_q  <= pos_q + POS_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/sbsp_queue.sv
// Short FIFO of packed groups between the front end and the serializer.
// Depends on sbsp_pkg for the entry type.
`default_nettype none

module sbsp_queue #(
	parameter int unsigned DEPTH = sbsp_pkg::QUEUE_DEPTH_D
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     wr_en,
	input  sbsp_pkg::pack_entry_t   wr_entry,
	output logic                    full,
	input  wire                     rd_en,
	output sbsp_pkg::pack_entry_t   rd_entry,
	output logic                    empty
);
	import sbsp_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	pack_entry_t      mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && !empty;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/sbsp_back.sv
// Back end of the packer: serializes one queued group into output bytes.
// Depends on sbsp_pkg; drains sbsp_queue.
`default_nettype none

module sbsp_back (
	input  wire                           clk,
	input  wire                           arst_n,
	input  sbsp_pkg::pack_entry_t         q_entry,
	input  wire                           q_empty,
	output logic                          q_pop,
	output logic [sbsp_pkg::BYTE_W-1:0]   out_byte,
	output logic                          out_last,
	output logic                          empty,
	input  wire                           pop
);
	import sbsp_pkg::*;

	logic [WORD_W-1:0] word_q;
	logic [BIDX_W-1:0] nbytes_m1_q;
	logic              last_q;
	logic [BIDX_W-1:0] idx_q;
	logic              busy_q;
	logic [WORD_W-1:0] shifted;
	logic              at_end;
	logic              take;

	assign shifted  = word_q >> {idx_q, 3'b000};
	assign out_byte = shifted[BYTE_W-1:0];
	assign at_end   = (idx_q == nbytes_m1_q);
	assign out_last = last_q && at_end;
	assign empty    = !busy_q;
	assign take     = pop && busy_q;

	// A new group is loaded when the holding register is free or its final
	// byte leaves in this cycle, so bytes stream without a bubble.
	assign q_pop = !q_empty && (!busy_q || (take && at_end));

	always_ff @(posedge clk) begin
		if (q_pop) begin
			word_q      <= q_entry.word;
			nbytes_m1_q <= q_entry.nbytes_m1;
			last_q      <= q_entry.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (take) begin
			if (at_end) begin
				busy_q <= 1'b0;
				idx_q  <= '0;
			end else begin
				idx_q <= idx_q + BIDX_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/six_bit_stream_packer.sv
// Top level of the six-bit stream packer.
// Depends on sbsp_pkg and instantiates sbsp_front, sbsp_queue and sbsp_back.
//
// Usage:
//   The input side looks like a queue: a transaction takes place at a rising
//   edge where push is high and full is low, carrying in_byte and in_last.
//   Eight bytes form a group; byte k is ORed into a 48-bit word at bit 6k and
//   bits above bit 47 are dropped. A full group gives six output bytes, least
//   significant first. A byte flagged by in_last closes a partial group of r
//   bytes, which gives ceil(6r/8) bytes, and the final one carries out_last.
//   The output side also looks like a queue: while empty is low the oldest
//   byte is on out_byte and out_last, and a transaction takes place at a
//   rising edge where pop is high and empty is low.
//
// Timing:
//   One input byte can be taken every cycle while full is low. A closed group
//   is written into a queue of QUEUE_DEPTH groups at the accept edge and its
//   first byte shows on the outputs once the serializer is free and loads it.
//   The serializer gives one byte per cycle while pop is high, reloads in the
//   same cycle its last byte leaves, so eight steady inputs give six outputs.
//   When the receiver stalls, output holds steady; groups collect in the
//   queue, and full rises only once the queue holds QUEUE_DEPTH groups.
//   Asynchronous reset clears the partial group, the queue and the output.
`default_nettype none

module six_bit_stream_packer #(
	parameter int unsigned QUEUE_DEPTH = sbsp_pkg::QUEUE_DEPTH_D
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire  [sbsp_pkg::BYTE_W-1:0]   in_byte,
	input  wire                           in_last,
	input  wire                           push,
	output logic                          full,
	output logic [sbsp_pkg::BYTE_W-1:0]   out_byte,
	output logic                          out_last,
	output logic                          empty,
	input  wire                           pop
);
	import sbsp_pkg::*;

	pack_entry_t wr_entry;
	pack_entry_t rd_entry;
	logic        q_push;
	logic        q_full;
	logic        q_pop;
	logic        q_empty;

	// Input backpressure comes only from the group queue.
	assign full = q_full;

	sbsp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_byte (in_byte),
		.in_last (in_last),
		.push    (push),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (wr_entry)
	);

	sbsp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_push),
		.wr_entry (wr_entry),
		.full     (q_full),
		.rd_en    (q_pop),
		.rd_entry (rd_entry),
		.empty    (q_empty)
	);

	sbsp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_entry  (rd_entry),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.out_byte (out_byte),
		.out_last (out_last),
		.empty    (empty),
		.pop      (pop)
	);

endmodule

`default_nettype wire

FILE: verif/tb_six_bit_stream_packer.sv
// Self-checking testbench for the six-bit stream packer.
// Depends on sbsp_pkg for widths and on the six_bit_stream_packer RTL.
// Input bytes are scored against a behavioral packer; output bytes are checked in order.
`default_nettype none

module tb_six_bit_stream_packer;
	import sbsp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// One input transaction waiting to be driven. The phase tag selects the
	// idling rates, and the drain flag makes the driver hold off until every
	// packed byte predicted so far has been popped.
	typedef struct {
		logic [BYTE_W-1:0] data;
		logic              fin;
		int                phase;
		bit                drain;
	} stream_item_t;

	// One packed output byte as the predictor expects it.
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              fin;
	} packed_byte_t;

	localparam int N_PHASES = 3;

	logic              clk;
	logic              arst_n;
	logic [BYTE_W-1:0] in_byte;
	logic              in_last;
	logic              push;
	logic              full;
	logic [BYTE_W-1:0] out_byte;
	logic              out_last;
	logic              empty;
	logic              pop;

	stream_item_t pending_items[$];
	packed_byte_t expected_bytes[$];

	// Behavioral copy of the packer state: the word being built and the
	// number of bytes already in the current group.
	logic [WORD_W-1:0] group_word;
	logic [POS_W-1:0]  group_fill;

	int error_count;
	int idle_phase;

	six_bit_stream_packer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.push     (push),
		.full     (full),
		.out_byte (out_byte),
		.out_last (out_last),
		.empty    (empty),
		.pop      (pop)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The sender idles 16 percent of the time in the first phase and 45 in
	// the second; the receiver does the opposite; the last phase runs flat out.
	function automatic int send_idle_pct(input int phase);
		case (phase)
			0:       return 16;
			1:       return 45;
			default: return 0;
		endcase
	endfunction

	function automatic int recv_idle_pct(input int phase);
		case (phase)
			0:       return 45;
			1:       return 16;
			default: return 0;
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= 100) begin
			$display("MISMATCH at %0t: %s", $realtime, msg);
		end
	endtask

	function automatic void add_item(input logic [BYTE_W-1:0] data, input logic fin,
			input int phase, input bit drain);
		stream_item_t item;
		item.data  = data;
		item.fin   = fin;
		item.phase = phase;
		item.drain = drain;
		pending_items.push_back(item);
	endfunction

	// Folds one accepted byte into the group word at bit 6*position and, when
	// the group closes (eighth byte or final flag), queues the low
	// ceil(6r/8) bytes of the word with the final flag on the last of them.
	function automatic void pack_and_predict(input logic [BYTE_W-1:0] data, input logic fin);
		int           held;
		int           n_out;
		packed_byte_t pb;
		held = int'(group_fill) + 1;
		group_word = group_word | (WORD_W'(data) << (6 * int'(group_fill)));
		if (held < 8 && !fin) begin
			group_fill = POS_W'(held);
			return;
		end
		n_out = (6 * held + 7) / 8;
		for (int i = 0; i < n_out; i++) begin
			pb.data = group_word[8*i +: 8];
			pb.fin  = fin && (i == n_out - 1);
			expected_bytes.push_back(pb);
		end
		group_word = '0;
		group_fill = '0;
	endfunction

	// Driver. An item stays on the inputs until the edge that accepts it;
	// only then is the next one taken from the pending queue, or push lowered
	// for an idle cycle. The prediction is made at the accepting edge.
	always @(posedge clk) begin : drive_proc
		stream_item_t item;
		if (arst_n) begin
			if (push && !full) begin
				pack_and_predict(in_byte, in_last);
			end
			if (!(push && full)) begin
				if (pending_items.size() > 0 &&
						(!pending_items[0].drain || expected_bytes.size() == 0) &&
						$urandom_range(99) >= send_idle_pct(pending_items[0].phase)) begin
					item = pending_items.pop_front();
					in_byte    <= item.data;
					in_last    <= item.fin;
					push       <= 1'b1;
					idle_phase <= item.phase;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Monitor. Each popped byte is compared with the oldest prediction, and
	// pop is redrawn every cycle according to the receiver's idling rate.
	always @(posedge clk) begin : check_proc
		packed_byte_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %02h last %0b",
						out_byte, out_last));
				end else begin
					want = expected_bytes.pop_front();
					if (out_byte !== want.data) begin
						report_mismatch($sformatf("out_byte %02h, expected %02h",
							out_byte, want.data));
					end
					if (out_last !== want.fin) begin
						report_mismatch($sformatf("out_last %0b, expected %0b",
							out_last, want.fin));
					end
				end
			end
			pop <= ($urandom_range(99) >= recv_idle_pct(idle_phase));
		end
	end

	initial begin
		int n_random;
		int len;
		int phase;
		int last_phase;
		int wait_cycles;
		logic [BYTE_W-1:0] value;

		clk         = 1'b0;
		arst_n      = 1'b0;
		in_byte     = '0;
		in_last     = 1'b0;
		push        = 1'b0;
		pop         = 1'b0;
		group_word  = '0;
		group_fill  = '0;
		error_count = 0;
		idle_phase  = 0;

		// Directed part. A lone final byte closes a one-byte group.
		add_item(8'h3F, 1'b1, 0, 1'b0);
		// Two bytes above 63: the high bits of the first overlap the second.
		add_item(8'hFF, 1'b0, 0, 1'b0);
		add_item(8'hFF, 1'b1, 0, 1'b0);
		// A full group whose eighth byte is also final; the 0xFF byte at the
		// top position loses the bits shifted past bit 47.
		add_item(8'h00, 1'b0, 0, 1'b1);
		add_item(8'h3F, 1'b0, 0, 1'b0);
		add_item(8'h2A, 1'b0, 0, 1'b0);
		add_item(8'h15, 1'b0, 0, 1'b0);
		add_item(8'hFF, 1'b0, 0, 1'b0);
		add_item(8'h80, 1'b0, 0, 1'b0);
		add_item(8'h01, 1'b0, 0, 1'b0);
		add_item(8'hFF, 1'b1, 0, 1'b0);
		// A full group that is not final, followed by a three-byte final group.
		for (int k = 0; k < 8; k++) begin
			add_item(8'h3F, 1'b0, 0, k == 0);
		end
		add_item(8'h00, 1'b0, 0, 1'b0);
		add_item(8'h40, 1'b0, 0, 1'b0);
		add_item(8'hC0, 1'b1, 0, 1'b0);

		// Random part: streams of random length, mostly 6-bit content with
		// some full-range bytes, each stream closed by a final byte. Short
		// streams are sprinkled in to hit partial groups often.
		n_random   = 0;
		last_phase = 0;
		while (n_random < 83) begin
			phase = (n_random < 28) ? 0 : (n_random < 56) ? 1 : 2;
			len = ($urandom_range(3) == 0) ? $urandom_range(1, 7) : $urandom_range(1, 20);
			for (int k = 0; k < len; k++) begin
				value = ($urandom_range(3) == 0) ? BYTE_W'($urandom_range(255))
					: BYTE_W'($urandom_range(63));
				add_item(value, k == len - 1, phase, k == 0 && phase != last_phase);
			end
			last_phase = phase;
			n_random += len;
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Sampled away from the rising edge so the driver's updates have settled.
		while (pending_items.size() > 0 || push) begin
			@(negedge clk);
		end
		wait_cycles = 0;
		while (expected_bytes.size() > 0 && wait_cycles < 20000) begin
			@(negedge clk);
			wait_cycles++;
		end
		if (expected_bytes.size() > 0) begin
			report_mismatch($sformatf("%0d predicted bytes never arrived",
				expected_bytes.size()));
		end
		// Give any stray output a chance to show up and be flagged.
		repeat (20) @(posedge clk);

		if (error_count == 0) begin
			$display("tb_six_bit_stream_packer: done, clean");
		end else begin
			$display("tb_six_bit_stream_packer: done, errors");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("tb_six_bit_stream_packer: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
